// ----- sv/etl_pkg.sv -----
package etl_pkg;

  localparam int NODE_W   = 10;
  localparam int DEPTH_W  = 10;
  localparam int STATUS_W = 2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_SEEN  = 2'd2;

  typedef struct packed {
    logic               is_query;
    logic               last;
    logic               bad_node;
    logic [NODE_W-1:0]  node;
    logic [DEPTH_W-1:0] depth;
    logic [NODE_W-1:0]  node_b;
  } etl_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_BLD_INIT,
    ST_BLD_CHK,
    ST_BLD_RD,
    ST_BLD_DEP,
    ST_BLD_WR,
    ST_Q_FP,
    ST_Q_ORD,
    ST_Q_LOG,
    ST_Q_MT,
    ST_Q_DEP,
    ST_Q_PICK,
    ST_Q_NODE,
    ST_RES
  } etl_state_e;

endpackage

// ----- sv/etl_front.sv -----
module etl_front import etl_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_cmd_i,
  input  logic        in_last_i,
  input  logic [NODE_W-1:0]  in_node_i,
  input  logic [DEPTH_W-1:0] in_depth_i,
  input  logic [NODE_W-1:0]  in_node_b_i,
  output logic        q_valid_o,
  output etl_item_t   q_item_o,
  input  logic        q_pop_i
);

  etl_item_t  entry_q [2];
  etl_item_t  item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;

  always_comb begin
    item.is_query = (in_cmd_i == CMD_QUERY);
    item.last     = in_last_i;
    item.bad_node = (32'(in_node_i) >= MAX_NODES) || (32'(in_node_b_i) >= MAX_NODES);
    item.node     = in_node_i;
    item.depth    = in_depth_i;
    item.node_b   = in_node_b_i;
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (fill_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

// ----- sv/etl_back.sv -----
module etl_back import etl_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int TOUR_LEN   = 2048,
  parameter int LOG_LEVELS = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  etl_item_t           q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [NODE_W-1:0]   out_ancestor_o,
  output logic [STATUS_W-1:0] out_status_o
);

  localparam int PW  = $clog2(TOUR_LEN);
  localparam int CW  = $clog2(TOUR_LEN + 1);
  localparam int NAW = $clog2(MAX_NODES);
  localparam int KIW = $clog2(LOG_LEVELS);
  localparam int KW  = $clog2(LOG_LEVELS + 1);

  logic [NODE_W-1:0]  nodes_mem [TOUR_LEN];
  logic [DEPTH_W-1:0] dep_mem   [TOUR_LEN];
  logic [PW:0]        fp_mem    [MAX_NODES];
  logic [PW-1:0]      mt_mem    [LOG_LEVELS][TOUR_LEN];

  etl_state_e state_q, state_d;
  etl_item_t  cur_q, cur_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           ready_q, ready_d;
  logic [NAW-1:0] clr_q, clr_d;
  logic           clr_load_q, clr_load_d;
  logic [KW-1:0]  k_q, k_d;
  logic [PW-1:0]  j_q, j_d;
  logic [PW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [NODE_W-1:0]   res_anc_q, res_anc_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;
  logic                out_valid_q;
  logic [NODE_W-1:0]   out_anc_q;
  logic [STATUS_W-1:0] out_st_q;
  logic                out_load;

  logic                ld_we;
  logic [PW-1:0]       ld_waddr;
  logic                nodes_re;
  logic [PW-1:0]       nodes_raddr;
  logic [NODE_W-1:0]   nodes_rd_q;
  logic                dep_re;
  logic [PW-1:0]       dep_raddr_a, dep_raddr_b;
  logic [DEPTH_W-1:0]  dep_ra_q, dep_rb_q;
  logic                fp_we;
  logic [NAW-1:0]      fp_waddr;
  logic [PW:0]         fp_wdata;
  logic                fp_re;
  logic [NAW-1:0]      fp_raddr_a, fp_raddr_b;
  logic [PW:0]         fp_ra_q, fp_rb_q;
  logic                mt_we;
  logic [KIW-1:0]      mt_wk;
  logic [PW-1:0]       mt_wj, mt_wdata;
  logic                mt_re;
  logic [KIW-1:0]      mt_rk;
  logic [PW-1:0]       mt_raddr_a, mt_raddr_b;
  logic [PW-1:0]       mt_ra_q, mt_rb_q;

  logic [31:0]   span_w;
  logic          lvl_ok, ent_ok, node_in;
  logic [CW-1:0] len;
  logic [KW-1:0] lg;
  logic [PW-1:0] pick;

  assign span_w  = 32'd1 << k_q;
  assign lvl_ok  = (32'(k_q) < LOG_LEVELS) && (span_w <= 32'(cnt_q));
  assign ent_ok  = (32'(j_q) + span_w) <= 32'(cnt_q);
  assign node_in = 32'(cur_q.node) < MAX_NODES;
  assign len     = CW'(32'(hi_q) - 32'(lo_q) + 32'd1);
  assign pick    = (dep_ra_q < dep_rb_q) ? mt_ra_q : mt_rb_q;

  always_comb begin
    lg = '0;
    for (int i = 0; i < CW; i++) begin
      if (len[i]) begin
        lg = KW'(i);
      end
    end
    if (32'(lg) > LOG_LEVELS - 1) begin
      lg = KW'(LOG_LEVELS - 1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (32'(clr_q) == MAX_NODES - 1) begin
          state_d = clr_load_q ? ST_LD_RD : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (!q_item_i.is_query) begin
            state_d = ready_q ? ST_CLEAR : ST_LD_RD;
          end else if (!ready_q || q_item_i.bad_node) begin
            state_d = ST_RES;
          end else begin
            state_d = ST_Q_FP;
          end
        end
      end
      ST_LD_RD: begin
        if (32'(cnt_q) < TOUR_LEN) begin
          state_d = ST_LD_WR;
        end else begin
          state_d = cur_q.last ? ST_BLD_INIT : ST_IDLE;
        end
      end
      ST_LD_WR:    state_d = cur_q.last ? ST_BLD_INIT : ST_IDLE;
      ST_BLD_INIT: state_d = ST_BLD_CHK;
      ST_BLD_CHK: begin
        if (!lvl_ok) begin
          state_d = ST_IDLE;
        end else if (ent_ok) begin
          state_d = ST_BLD_RD;
        end
      end
      ST_BLD_RD:  state_d = ST_BLD_DEP;
      ST_BLD_DEP: state_d = ST_BLD_WR;
      ST_BLD_WR:  state_d = ST_BLD_CHK;
      ST_Q_FP:    state_d = ST_Q_ORD;
      ST_Q_ORD:   state_d = (fp_ra_q[PW] && fp_rb_q[PW]) ? ST_Q_LOG : ST_RES;
      ST_Q_LOG:   state_d = ST_Q_MT;
      ST_Q_MT:    state_d = ST_Q_DEP;
      ST_Q_DEP:   state_d = ST_Q_PICK;
      ST_Q_PICK:  state_d = ST_Q_NODE;
      ST_Q_NODE:  state_d = ST_RES;
      ST_RES: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    ready_d    = ready_q;
    clr_d      = clr_q;
    clr_load_d = clr_load_q;
    k_d        = k_q;
    j_d        = j_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    res_anc_d  = res_anc_q;
    res_st_d   = res_st_q;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    ld_we      = 1'b0;
    ld_waddr   = PW'(cnt_q);
    nodes_re   = 1'b0;
    nodes_raddr = pick;
    dep_re     = 1'b0;
    dep_raddr_a = mt_ra_q;
    dep_raddr_b = mt_rb_q;
    fp_we      = 1'b0;
    fp_waddr   = clr_q;
    fp_wdata   = '0;
    fp_re      = 1'b0;
    fp_raddr_a = NAW'(cur_q.node);
    fp_raddr_b = NAW'(cur_q.node_b);
    mt_we      = 1'b0;
    mt_wk      = '0;
    mt_wj      = PW'(cnt_q);
    mt_wdata   = PW'(cnt_q);
    mt_re      = 1'b0;
    mt_rk      = KIW'(k_q);
    mt_raddr_a = lo_q;
    mt_raddr_b = PW'(32'(hi_q) + 32'd1 - span_w);
    case (state_q)
      ST_CLEAR: begin
        fp_we = 1'b1;
        clr_d = clr_q + NAW'(1);
        if (32'(clr_q) == MAX_NODES - 1) begin
          clr_d      = '0;
          clr_load_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          if (!q_item_i.is_query) begin
            if (ready_q) begin
              ready_d    = 1'b0;
              cnt_d      = '0;
              clr_d      = '0;
              clr_load_d = 1'b1;
            end
          end else if (!ready_q) begin
            res_anc_d = '0;
            res_st_d  = STATUS_NOT_BUILT;
          end else if (q_item_i.bad_node) begin
            res_anc_d = '0;
            res_st_d  = STATUS_NOT_SEEN;
          end
        end
      end
      ST_LD_RD: begin
        if (32'(cnt_q) < TOUR_LEN) begin
          ld_we = 1'b1;
          mt_we = 1'b1;
          fp_re = 1'b1;
        end
      end
      ST_LD_WR: begin
        if (node_in && !fp_ra_q[PW]) begin
          fp_we    = 1'b1;
          fp_waddr = NAW'(cur_q.node);
          fp_wdata = {1'b1, PW'(cnt_q)};
        end
        cnt_d = cnt_q + CW'(1);
      end
      ST_BLD_INIT: begin
        k_d = KW'(1);
        j_d = '0;
      end
      ST_BLD_CHK: begin
        if (!lvl_ok) begin
          ready_d = 1'b1;
        end else if (!ent_ok) begin
          k_d = k_q + KW'(1);
          j_d = '0;
        end
      end
      ST_BLD_RD: begin
        mt_re      = 1'b1;
        mt_rk      = KIW'(k_q - KW'(1));
        mt_raddr_a = j_q;
        mt_raddr_b = PW'(32'(j_q) + (span_w >> 1));
      end
      ST_BLD_DEP: dep_re = 1'b1;
      ST_BLD_WR: begin
        mt_we    = 1'b1;
        mt_wk    = KIW'(k_q);
        mt_wj    = j_q;
        mt_wdata = pick;
        j_d      = j_q + PW'(1);
      end
      ST_Q_FP: fp_re = 1'b1;
      ST_Q_ORD: begin
        if (fp_ra_q[PW] && fp_rb_q[PW]) begin
          if (fp_ra_q[PW-1:0] > fp_rb_q[PW-1:0]) begin
            lo_d = fp_rb_q[PW-1:0];
            hi_d = fp_ra_q[PW-1:0];
          end else begin
            lo_d = fp_ra_q[PW-1:0];
            hi_d = fp_rb_q[PW-1:0];
          end
        end else begin
          res_anc_d = '0;
          res_st_d  = STATUS_NOT_SEEN;
        end
      end
      ST_Q_LOG:  k_d = lg;
      ST_Q_MT:   mt_re = 1'b1;
      ST_Q_DEP:  dep_re = 1'b1;
      ST_Q_PICK: nodes_re = 1'b1;
      ST_Q_NODE: begin
        res_anc_d = nodes_rd_q;
        res_st_d  = STATUS_OK;
      end
      ST_RES: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      nodes_mem[ld_waddr] <= cur_q.node;
      dep_mem[ld_waddr]   <= cur_q.depth;
    end
    if (nodes_re) begin
      nodes_rd_q <= nodes_mem[nodes_raddr];
    end
    if (dep_re) begin
      dep_ra_q <= dep_mem[dep_raddr_a];
      dep_rb_q <= dep_mem[dep_raddr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fp_we) begin
      fp_mem[fp_waddr] <= fp_wdata;
    end
    if (fp_re) begin
      fp_ra_q <= fp_mem[fp_raddr_a];
      fp_rb_q <= fp_mem[fp_raddr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mt_we) begin
      mt_mem[mt_wk][mt_wj] <= mt_wdata;
    end
    if (mt_re) begin
      mt_ra_q <= mt_mem[mt_rk][mt_raddr_a];
      mt_rb_q <= mt_mem[mt_rk][mt_raddr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    k_q       <= k_d;
    j_q       <= j_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_anc_q <= res_anc_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_anc_q <= res_anc_q;
      out_st_q  <= res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      ready_q     <= 1'b0;
      clr_q       <= '0;
      clr_load_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ready_q    <= ready_d;
      clr_q      <= clr_d;
      clr_load_q <= clr_load_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_ancestor_o = out_anc_q;
  assign out_status_o   = out_st_q;

`ifndef SYNTHESIS
  a_clear_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !ready_q)
    else $error("clear pass runs while the table is marked built");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= TOUR_LEN)
    else $error("tour entry count exceeds capacity");
  a_ok_needs_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_st_q == STATUS_OK)) |-> ready_q)
    else $error("ok result issued without a built table");
  a_build_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLD_CHK) |=> ((state_q == ST_IDLE) || !ready_q || $past(!lvl_ok)))
    else $error("table marked built before the build pass finished");
`endif

endmodule

// ----- sv/euler_tour_lca_sparse_table.sv -----
// Channel  Dir  tdata                                 tuser          tlast
// s_axis   in   node[9:0] depth[19:10] node_b[29:20]  cmd            last
// m_axis   out  ancestor[9:0]                         status[1:0]    -
//
// The first load after a build first runs a clear pass over the first-position
// memory, covering all MAX_NODES entries, as does reset.
// The build pass fills the sparse table one entry at a time.
// A query runs a chain of registered memory reads: positions, table, depths, node.
// A two-entry queue lets requests enter while the sequencer is busy or the
// result register waits for m_axis_tready_i.
module euler_tour_lca_sparse_table import etl_pkg::*; #(
  parameter int MAX_NODES  = 1024,
  parameter int TOUR_LEN   = 2048,
  parameter int LOG_LEVELS = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // node, depth, node_b from bit 0 up.
  input  logic [31:0] s_axis_tdata_i,
  // cmd.
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // ancestor.
  output logic [15:0] m_axis_tdata_o,
  // status.
  output logic [1:0]  m_axis_tuser_o
);

  logic              q_valid, q_pop;
  etl_item_t         q_item;
  logic [NODE_W-1:0] ancestor;

  etl_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .in_node_i   (s_axis_tdata_i[9:0]),
    .in_depth_i  (s_axis_tdata_i[19:10]),
    .in_node_b_i (s_axis_tdata_i[29:20]),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  etl_back #(
    .MAX_NODES  (MAX_NODES),
    .TOUR_LEN   (TOUR_LEN),
    .LOG_LEVELS (LOG_LEVELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_ancestor_o (ancestor),
    .out_status_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {6'b0, ancestor};

endmodule
